// ===== rtl/core/sst_pkg.sv =====
// Package for the script source tokenizer: item types, token codes,
// keyword table and character class helpers. No dependencies.
`timescale 1ns / 1ps

package sst_pkg;

  // Default sizes.
  localparam int unsigned KeywordCharsDefault = 8;
  localparam int unsigned PositionBitsDefault = 16;

  // Token class codes.
  localparam logic [5:0] TK_UNKNOWN  = 6'd0;
  localparam logic [5:0] TK_EOF      = 6'd1;
  localparam logic [5:0] TK_IDENT    = 6'd2;
  localparam logic [5:0] TK_INT      = 6'd3;
  localparam logic [5:0] TK_FLOAT    = 6'd4;
  localparam logic [5:0] TK_STRING   = 6'd5;
  localparam logic [5:0] TK_LBRACE   = 6'd6;
  localparam logic [5:0] TK_RBRACE   = 6'd7;
  localparam logic [5:0] TK_LPAREN   = 6'd8;
  localparam logic [5:0] TK_RPAREN   = 6'd9;
  localparam logic [5:0] TK_LBRACKET = 6'd10;
  localparam logic [5:0] TK_RBRACKET = 6'd11;
  localparam logic [5:0] TK_KW_FIRST = 6'd12;
  localparam logic [5:0] TK_SEMI     = 6'd22;
  localparam logic [5:0] TK_COLON    = 6'd23;
  localparam logic [5:0] TK_COMMA    = 6'd24;
  localparam logic [5:0] TK_PLUS     = 6'd25;
  localparam logic [5:0] TK_MINUS    = 6'd26;
  localparam logic [5:0] TK_STAR     = 6'd27;
  localparam logic [5:0] TK_SLASH    = 6'd28;
  localparam logic [5:0] TK_PERCENT  = 6'd29;
  localparam logic [5:0] TK_EQ       = 6'd30;
  localparam logic [5:0] TK_NE       = 6'd31;
  localparam logic [5:0] TK_GT       = 6'd32;
  localparam logic [5:0] TK_GE       = 6'd33;
  localparam logic [5:0] TK_LT       = 6'd34;
  localparam logic [5:0] TK_LE       = 6'd35;
  localparam logic [5:0] TK_ASSIGN   = 6'd36;
  localparam logic [5:0] TK_AND      = 6'd37;
  localparam logic [5:0] TK_OR       = 6'd38;
  localparam logic [5:0] TK_NOT      = 6'd39;

  // Keyword table, padded with spaces to eight characters.
  localparam int unsigned KwCount = 10;
  localparam logic [63:0] KW_TEXT [KwCount] = '{
    "else    ", "false   ", "for     ", "function", "if      ",
    "null    ", "return  ", "true    ", "var     ", "while   "
  };
  localparam logic [3:0] KW_LEN [KwCount] = '{
    4'd4, 4'd5, 4'd3, 4'd8, 4'd2, 4'd4, 4'd6, 4'd4, 4'd3, 4'd5
  };

  // One input item and one result item.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_mark;
  } in_item_t;

  typedef struct packed {
    logic        out_kind;
    logic [5:0]  token_code;
    logic [20:0] code_point;
    logic [15:0] line;
    logic [15:0] column;
    logic        last;
  } out_item_t;

  // Results of one input item, handed from the scanner to the queue.
  typedef struct packed {
    logic [1:0]           count;
    out_item_t [2:0]      items;
  } res_bundle_t;

  function automatic out_item_t make_item(logic kind, logic [5:0] code, logic [20:0] cp);
    out_item_t r;
    r            = '0;
    r.out_kind   = kind;
    r.token_code = code;
    r.code_point = cp;
    return r;
  endfunction

  function automatic logic is_space(logic [20:0] c);
    return c == 21'd32 || c == 21'd9 || c == 21'd10 || c == 21'd11 ||
           c == 21'd12 || c == 21'd13;
  endfunction

  function automatic logic is_letter(logic [20:0] c);
    return (c >= 21'd97 && c <= 21'd122) || (c >= 21'd65 && c <= 21'd90);
  endfunction

  function automatic logic is_digit(logic [20:0] c);
    return c >= 21'd48 && c <= 21'd57;
  endfunction

  // Hex digit value with a valid flag in the top bit.
  function automatic logic [4:0] hex_val(logic [20:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 21'd48 && c <= 21'd57) begin
      r = {1'b1, 4'(c - 21'd48)};
    end else if (c >= 21'd65 && c <= 21'd70) begin
      r = {1'b1, 4'(c - 21'd55)};
    end else if (c >= 21'd97 && c <= 21'd102) begin
      r = {1'b1, 4'(c - 21'd87)};
    end
    return r;
  endfunction

  // Code of a character that is a token on its own, with a valid flag.
  function automatic logic [6:0] single_code(logic [20:0] c);
    logic [6:0] r;
    case (c)
      21'd123: r = {1'b1, TK_LBRACE};
      21'd125: r = {1'b1, TK_RBRACE};
      21'd40:  r = {1'b1, TK_LPAREN};
      21'd41:  r = {1'b1, TK_RPAREN};
      21'd91:  r = {1'b1, TK_LBRACKET};
      21'd93:  r = {1'b1, TK_RBRACKET};
      21'd59:  r = {1'b1, TK_SEMI};
      21'd58:  r = {1'b1, TK_COLON};
      21'd44:  r = {1'b1, TK_COMMA};
      21'd43:  r = {1'b1, TK_PLUS};
      21'd45:  r = {1'b1, TK_MINUS};
      21'd42:  r = {1'b1, TK_STAR};
      21'd37:  r = {1'b1, TK_PERCENT};
      default: r = '0;
    endcase
    return r;
  endfunction

  // Characters that may start a two-character operator or a comment.
  function automatic logic is_op_start(logic [20:0] c);
    return c == 21'd47 || c == 21'd38 || c == 21'd124 || c == 21'd62 ||
           c == 21'd60 || c == 21'd61 || c == 21'd33;
  endfunction

  // Meaning of a pending operator character that stands alone.
  function automatic logic [5:0] alone_code(logic [6:0] p);
    logic [5:0] r;
    case (p)
      7'd47:   r = TK_SLASH;
      7'd62:   r = TK_GT;
      7'd60:   r = TK_LT;
      7'd61:   r = TK_ASSIGN;
      7'd33:   r = TK_NOT;
      default: r = TK_UNKNOWN;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/sst_scan.sv =====
// Scanner core: holds the tokenizer state and works out the results of one
// accepted item in a single pass. Depends on sst_pkg.
`timescale 1ns / 1ps

module sst_scan
  import sst_pkg::*;
#(
  parameter int unsigned KEYWORD_CHARS = KeywordCharsDefault,
  parameter int unsigned POSITION_BITS = PositionBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        take_i,
  input  in_item_t    item_i,
  output res_bundle_t res_o
);

  localparam int unsigned LenBits = $clog2(KEYWORD_CHARS + 2);
  localparam int unsigned IdxBits = $clog2(KEYWORD_CHARS);
  localparam logic [POSITION_BITS-1:0] PosMax = '1;

  // Scanner modes.
  localparam logic [4:0] M_IDLE    = 5'd0;
  localparam logic [4:0] M_IDENT   = 5'd1;
  localparam logic [4:0] M_INT     = 5'd2;
  localparam logic [4:0] M_DOT     = 5'd3;
  localparam logic [4:0] M_FRAC    = 5'd4;
  localparam logic [4:0] M_EXP     = 5'd5;
  localparam logic [4:0] M_EXPSIGN = 5'd6;
  localparam logic [4:0] M_EXPDIG  = 5'd7;
  localparam logic [4:0] M_STR     = 5'd8;
  localparam logic [4:0] M_ESC     = 5'd9;
  localparam logic [4:0] M_HEX     = 5'd10;
  localparam logic [4:0] M_OP      = 5'd11;
  localparam logic [4:0] M_LINEC   = 5'd12;
  localparam logic [4:0] M_BLOCK   = 5'd13;
  localparam logic [4:0] M_BSTAR   = 5'd14;

  logic [4:0]               mode_q, mode_d;
  logic [6:0]               pend_q, pend_d;
  logic [LenBits-1:0]       len_q, len_d;
  logic [15:0]              hacc_q, hacc_d;
  logic [2:0]               hcnt_q, hcnt_d;
  logic [20:0]              part_q, part_d;
  logic [1:0]               rem_q, rem_d;
  logic [POSITION_BITS-1:0] line_q, line_d, col_q, col_d;
  logic [6:0]               kw_buf_q [KEYWORD_CHARS];
  logic                     kw_we;
  logic [IdxBits-1:0]       kw_idx;

  logic [5:0]  ident_cd;
  logic [20:0] ch;
  logic [4:0]  hv;
  logic [6:0]  sc;

  // Outcome of scanning the current character from idle.
  logic [4:0]  idle_mode;
  logic        idle_emit, idle_pend, idle_ident;
  out_item_t   idle_item;

  // Keyword lookup over the stored identifier characters.
  always_comb begin
    logic hit;
    ident_cd = TK_IDENT;
    for (int j = KwCount - 1; j >= 0; j--) begin
      hit = (32'(KW_LEN[j]) <= KEYWORD_CHARS) && (len_q == LenBits'(KW_LEN[j]));
      for (int i = 0; i < 8; i++) begin
        if (i < int'(KW_LEN[j]) &&
            kw_buf_q[i] != KW_TEXT[j][62-8*i -: 7]) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        ident_cd = TK_KW_FIRST + 6'(j);
      end
    end
  end

  // Classification of a character seen between tokens.
  always_comb begin
    sc         = single_code(ch);
    idle_mode  = M_IDLE;
    idle_emit  = 1'b0;
    idle_pend  = 1'b0;
    idle_ident = 1'b0;
    idle_item  = '0;
    if (is_space(ch)) begin
      idle_mode = M_IDLE;
    end else if (is_letter(ch) || ch == 21'd95) begin
      idle_mode  = M_IDENT;
      idle_ident = 1'b1;
      idle_emit  = 1'b1;
      idle_item  = make_item(1'b0, TK_IDENT, ch);
    end else if (ch == 21'd34) begin
      idle_mode = M_STR;
    end else if (is_digit(ch)) begin
      idle_mode = M_INT;
      idle_emit = 1'b1;
      idle_item = make_item(1'b0, TK_INT, ch);
    end else if (ch == 21'd46) begin
      idle_mode = M_DOT;
      idle_emit = 1'b1;
      idle_item = make_item(1'b0, TK_FLOAT, ch);
    end else if (sc[6]) begin
      idle_emit = 1'b1;
      idle_item = make_item(1'b1, sc[5:0], '0);
    end else if (is_op_start(ch)) begin
      idle_mode = M_OP;
      idle_pend = 1'b1;
    end else begin
      idle_emit = 1'b1;
      idle_item = make_item(1'b1, TK_UNKNOWN, '0);
    end
  end

  // Next state and results of one item.
  always_comb begin
    logic [1:0]  n;
    logic        have_c, do_close, do_idle;
    logic [5:0]  close_cd;
    out_item_t   e0;
    mode_d   = mode_q;
    pend_d   = pend_q;
    len_d    = len_q;
    hacc_d   = hacc_q;
    hcnt_d   = hcnt_q;
    part_d   = part_q;
    rem_d    = rem_q;
    line_d   = line_q;
    col_d    = col_q;
    kw_we    = 1'b0;
    kw_idx   = '0;
    ch       = '0;
    hv       = '0;
    n        = '0;
    have_c   = 1'b0;
    do_close = 1'b0;
    do_idle  = 1'b0;
    close_cd = TK_UNKNOWN;
    e0       = '0;
    res_o    = '0;

    if (item_i.end_mark) begin
      // End of source: flush the open token, then end of file.
      col_d = (col_q == PosMax) ? col_q : col_q + 1'b1;
      e0    = make_item(1'b1, TK_UNKNOWN, '0);
      case (mode_q)
        M_IDENT:                  e0.token_code = ident_cd;
        M_INT:                    e0.token_code = TK_INT;
        M_FRAC, M_EXPDIG:         e0.token_code = TK_FLOAT;
        M_OP:                     e0.token_code = alone_code(pend_q);
        default:                  e0.token_code = TK_UNKNOWN;
      endcase
      case (mode_q)
        M_IDENT, M_INT, M_FRAC, M_EXPDIG, M_OP, M_DOT, M_EXP, M_EXPSIGN,
        M_STR, M_ESC, M_HEX: begin
          res_o.items[n] = e0;
          n = n + 2'd1;
        end
        default: ;
      endcase
      res_o.items[n] = make_item(1'b1, TK_EOF, '0);
      n      = n + 2'd1;
      mode_d = M_IDLE;
      pend_d = '0;
      part_d = '0;
      rem_d  = '0;
      hcnt_d = '0;
      hacc_d = '0;
    end else begin
      // Loose UTF-8 assembly by the lead byte.
      if (rem_q != 2'd0) begin
        part_d = {part_q[14:0], item_i.data_byte[5:0]};
        rem_d  = rem_q - 2'd1;
      end else if (item_i.data_byte < 8'h80) begin
        part_d = 21'(item_i.data_byte);
      end else if (item_i.data_byte >= 8'hf0) begin
        part_d = 21'(item_i.data_byte[2:0]);
        rem_d  = 2'd3;
      end else if (item_i.data_byte >= 8'he0) begin
        part_d = 21'(item_i.data_byte[3:0]);
        rem_d  = 2'd2;
      end else begin
        part_d = 21'(item_i.data_byte[4:0]);
        rem_d  = 2'd1;
      end
      if (rem_d == 2'd0) begin
        ch     = part_d;
        part_d = '0;
        have_c = 1'b1;
        col_d  = (col_q == PosMax) ? col_q : col_q + 1'b1;
        if (ch == 21'd10 || ch == 21'd13) begin
          line_d = (line_q == PosMax) ? line_q : line_q + 1'b1;
          col_d  = '0;
        end
      end
    end

    // Character step by scanner mode.
    if (have_c) begin
      hv = hex_val(ch);
      case (mode_q)
        M_IDENT: begin
          if (is_letter(ch) || is_digit(ch) || ch == 21'd95) begin
            if (32'(len_q) < KEYWORD_CHARS) begin
              kw_we  = 1'b1;
              kw_idx = len_q[IdxBits-1:0];
            end
            if (32'(len_q) <= KEYWORD_CHARS) begin
              len_d = len_q + 1'b1;
            end
            res_o.items[n] = make_item(1'b0, TK_IDENT, ch);
            n = n + 2'd1;
          end else begin
            do_close = 1'b1;
            close_cd = ident_cd;
          end
        end
        M_INT: begin
          if (is_digit(ch)) begin
            res_o.items[n] = make_item(1'b0, TK_INT, ch);
            n = n + 2'd1;
          end else if (ch == 21'd46 || ch == 21'd101 || ch == 21'd69) begin
            mode_d = (ch == 21'd46) ? M_FRAC : M_EXP;
            res_o.items[n] = make_item(1'b0, TK_FLOAT, ch);
            n = n + 2'd1;
          end else begin
            do_close = 1'b1;
            close_cd = TK_INT;
          end
        end
        M_DOT, M_EXPSIGN: begin
          if (is_digit(ch)) begin
            mode_d = (mode_q == M_DOT) ? M_FRAC : M_EXPDIG;
            res_o.items[n] = make_item(1'b0, TK_FLOAT, ch);
            n = n + 2'd1;
          end else begin
            do_close = 1'b1;
          end
        end
        M_FRAC: begin
          if (is_digit(ch)) begin
            res_o.items[n] = make_item(1'b0, TK_FLOAT, ch);
            n = n + 2'd1;
          end else if (ch == 21'd101 || ch == 21'd69) begin
            mode_d = M_EXP;
            res_o.items[n] = make_item(1'b0, TK_FLOAT, ch);
            n = n + 2'd1;
          end else begin
            do_close = 1'b1;
            close_cd = TK_FLOAT;
          end
        end
        M_EXP: begin
          if (ch == 21'd43 || ch == 21'd45 || is_digit(ch)) begin
            mode_d = is_digit(ch) ? M_EXPDIG : M_EXPSIGN;
            res_o.items[n] = make_item(1'b0, TK_FLOAT, ch);
            n = n + 2'd1;
          end else begin
            do_close = 1'b1;
          end
        end
        M_EXPDIG: begin
          if (is_digit(ch)) begin
            res_o.items[n] = make_item(1'b0, TK_FLOAT, ch);
            n = n + 2'd1;
          end else begin
            do_close = 1'b1;
            close_cd = TK_FLOAT;
          end
        end
        M_STR: begin
          if (ch == 21'd34) begin
            mode_d = M_IDLE;
            res_o.items[n] = make_item(1'b1, TK_STRING, '0);
            n = n + 2'd1;
          end else if (ch == 21'd92) begin
            mode_d = M_ESC;
          end else begin
            res_o.items[n] = make_item(1'b0, TK_STRING, ch);
            n = n + 2'd1;
          end
        end
        M_ESC: begin
          mode_d = M_STR;
          case (ch)
            21'd117: begin
              mode_d = M_HEX;
              hacc_d = '0;
              hcnt_d = '0;
            end
            21'd98, 21'd116, 21'd110, 21'd102, 21'd114, 21'd34, 21'd39, 21'd92: begin
              e0 = make_item(1'b0, TK_STRING, ch);
              if (ch == 21'd98)  e0.code_point = 21'd8;
              if (ch == 21'd116) e0.code_point = 21'd9;
              if (ch == 21'd110) e0.code_point = 21'd10;
              if (ch == 21'd102) e0.code_point = 21'd12;
              if (ch == 21'd114) e0.code_point = 21'd13;
              res_o.items[n] = e0;
              n = n + 2'd1;
            end
            default: do_close = 1'b1;
          endcase
        end
        M_HEX: begin
          if (!hv[4]) begin
            do_close = 1'b1;
          end else begin
            hacc_d = {hacc_q[11:0], hv[3:0]};
            hcnt_d = hcnt_q + 3'd1;
            if (hcnt_d >= 3'd4) begin
              res_o.items[n] = make_item(1'b0, TK_STRING, 21'(hacc_d));
              n = n + 2'd1;
              hcnt_d = '0;
              mode_d = M_STR;
            end
          end
        end
        M_OP: begin
          pend_d = '0;
          mode_d = M_IDLE;
          e0     = make_item(1'b1, TK_UNKNOWN, '0);
          if (pend_q == 7'd47 && ch == 21'd47) begin
            mode_d = M_LINEC;
          end else if (pend_q == 7'd47 && ch == 21'd42) begin
            mode_d = M_BLOCK;
          end else if (pend_q == 7'd38 && ch == 21'd38) begin
            e0.token_code = TK_AND;
          end else if (pend_q == 7'd124 && ch == 21'd124) begin
            e0.token_code = TK_OR;
          end else if (pend_q == 7'd61 && ch == 21'd61) begin
            e0.token_code = TK_EQ;
          end else if (pend_q == 7'd33 && ch == 21'd61) begin
            e0.token_code = TK_NE;
          end else if (pend_q == 7'd62 && ch == 21'd61) begin
            e0.token_code = TK_GE;
          end else if (pend_q == 7'd60 && ch == 21'd61) begin
            e0.token_code = TK_LE;
          end else begin
            do_close = 1'b1;
            close_cd = alone_code(pend_q);
          end
          if (!do_close && mode_d == M_IDLE) begin
            res_o.items[n] = e0;
            n = n + 2'd1;
          end
        end
        M_LINEC: begin
          if (ch == 21'd10 || ch == 21'd13) mode_d = M_IDLE;
        end
        M_BLOCK: begin
          if (ch == 21'd42) mode_d = M_BSTAR;
        end
        M_BSTAR: begin
          if (ch == 21'd47) begin
            mode_d = M_IDLE;
          end else if (ch != 21'd42) begin
            mode_d = M_BLOCK;
          end
        end
        default: do_idle = 1'b1;
      endcase
    end

    // Close the open token and scan the character again from idle.
    if (do_close) begin
      res_o.items[n] = make_item(1'b1, close_cd, '0);
      n = n + 2'd1;
      do_idle = 1'b1;
    end
    if (do_idle) begin
      mode_d = idle_mode;
      if (idle_pend) begin
        pend_d = ch[6:0];
      end
      if (idle_ident) begin
        kw_we  = 1'b1;
        kw_idx = '0;
        len_d  = LenBits'(1);
      end
      if (idle_emit) begin
        res_o.items[n] = idle_item;
        n = n + 2'd1;
      end
    end

    // Position and final flag go on every result of this item.
    res_o.count = n;
    for (int i = 0; i < 3; i++) begin
      res_o.items[i].line   = 16'(32'(line_d));
      res_o.items[i].column = 16'(32'(col_d));
      res_o.items[i].last   = (2'(i + 1) == n);
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      pend_q <= '0;
      len_q  <= '0;
      hacc_q <= '0;
      hcnt_q <= '0;
      part_q <= '0;
      rem_q  <= '0;
      line_q <= POSITION_BITS'(1);
      col_q  <= '0;
    end else if (take_i) begin
      mode_q <= mode_d;
      pend_q <= pend_d;
      len_q  <= len_d;
      hacc_q <= hacc_d;
      hcnt_q <= hcnt_d;
      part_q <= part_d;
      rem_q  <= rem_d;
      line_q <= line_d;
      col_q  <= col_d;
    end
  end

  // Identifier character store.
  always_ff @(posedge clk_i) begin
    if (take_i && kw_we) begin
      kw_buf_q[kw_idx] <= ch[6:0];
    end
  end

endmodule

// ===== rtl/core/sst_outq.sv =====
// Result queue: holds the up to three results of one item and hands them
// out one per cycle while the output is not stalled. Depends on sst_pkg.
`timescale 1ns / 1ps

module sst_outq
  import sst_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  res_bundle_t res_i,
  output logic        room_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o
);

  out_item_t  ent_q [3];
  logic [1:0] cnt_q, head_q;
  logic       pop;

  assign pop         = (cnt_q != 2'd0) && !out_stall_i;
  assign room_o      = (cnt_q == 2'd0) || (cnt_q == 2'd1 && !out_stall_i);
  assign out_valid_o = cnt_q != 2'd0;
  assign out_item_o  = ent_q[head_q];

  // Count and read pointer; a load replaces the drained queue.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      head_q <= '0;
    end else if (load_i) begin
      cnt_q  <= res_i.count;
      head_q <= '0;
    end else if (pop) begin
      cnt_q  <= cnt_q - 2'd1;
      head_q <= head_q + 2'd1;
    end
  end

  // Result entries.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int i = 0; i < 3; i++) begin
        ent_q[i] <= res_i.items[i];
      end
    end
  end

  // A load never overwrites results still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (cnt_q == 2'd0 || (cnt_q == 2'd1 && pop)))
    else $error("result queue overwritten");

  // The final result of an item is the last one in the queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.last |-> cnt_q == 2'd1)
    else $error("final flag before the end of the queue");

  // The pointer never runs past the three entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, head_q} + {1'b0, cnt_q}) <= 3'd3)
    else $error("result queue pointer out of range");

endmodule

// ===== rtl/core/script_source_tokenizer.sv =====
// Top level of the script source tokenizer: scanner core and result queue.
// Depends on sst_pkg, sst_scan and sst_outq.
`timescale 1ns / 1ps
//
// Channel  Direction  Handshake                Payload
// in       input      in_valid_i / in_stall_o  in_item_i  (data_byte, end_mark)
// out      output     out_valid_o / out_stall_i out_item_o (one result item)
//
// One byte is accepted per cycle when it causes at most one result and the
// output is not stalled. An item with two or three results holds the input
// while the result queue drains, one result per cycle when not stalled. Reset
// puts the scanner idle at line 1, column 0, with an empty queue. A stalled
// output holds the input once the queue cannot take the next item's results.

module script_source_tokenizer
  import sst_pkg::*;
#(
  parameter int unsigned KEYWORD_CHARS = KeywordCharsDefault,
  parameter int unsigned POSITION_BITS = PositionBitsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic        room, take;
  res_bundle_t res;

  assign in_stall_o = !room;
  assign take       = in_valid_i && room;

  sst_scan #(
    .KEYWORD_CHARS(KEYWORD_CHARS),
    .POSITION_BITS(POSITION_BITS)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .item_i (in_item_i),
    .res_o  (res)
  );

  sst_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take),
    .res_i       (res),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the script source tokenizer.
// Depends on sst_pkg and script_source_tokenizer; predicts tokens in a scoreboard class.
`timescale 1ns / 1ps

module tb_top;
  import sst_pkg::*;

  localparam int unsigned PosMax   = 65535;
  localparam int unsigned KwChars  = 8;
  localparam int unsigned CycleCap = 400000;

  // Scanner modes of the predictor.
  typedef enum int {
    SM_IDLE, SM_IDENT, SM_INT, SM_DOT, SM_FRAC, SM_EXP, SM_EXPSIGN, SM_EXPDIG,
    SM_STR, SM_ESC, SM_HEX, SM_OP, SM_LINEC, SM_BLOCK, SM_BSTAR
  } scan_mode_e;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  int  mismatches;
  int  cycles;
  bit  long_hold;
  bit  quiet;

  // Reports one mismatch and counts it.
  task automatic report(input string what);
    mismatches++;
    $display("mismatch at cycle %0d: %s", cycles, what);
  endtask

  // Token predictor and the queue of token results it has predicted.
  class token_scoreboard;
    out_item_t  pending[$];
    scan_mode_e mode;
    logic [6:0] op_char;
    logic [7:0] kw_buf [KwChars];
    int unsigned id_len, hex_acc, hex_cnt, u8_acc, u8_left, line_no, col_no;
    out_item_t  step_res[$];

    function void clear();
      mode = SM_IDLE; op_char = '0; id_len = 0; hex_acc = 0; hex_cnt = 0;
      u8_acc = 0; u8_left = 0; line_no = 1; col_no = 0;
      pending.delete();
    endfunction

    function void put(bit kind, logic [5:0] code, int unsigned cp);
      out_item_t r;
      if (step_res.size() >= 3) return;
      r = '0;
      r.out_kind = kind; r.token_code = code; r.code_point = cp[20:0];
      r.line = line_no[15:0]; r.column = col_no[15:0];
      step_res = {step_res, r};
    endfunction

    function logic [5:0] word_code();
      logic [63:0] txt;
      bit hit;
      for (int j = 0; j < KwCount; j++) begin
        if (KW_LEN[j] > KwChars || id_len != KW_LEN[j]) continue;
        txt = KW_TEXT[j];
        hit = 1;
        for (int i = 0; i < KW_LEN[j]; i++)
          if (kw_buf[i] != txt[63-8*i -: 8]) hit = 0;
        if (hit) return TK_KW_FIRST + 6'(j);
      end
      return TK_IDENT;
    endfunction

    function bit letter(int unsigned c); return (c>=97 && c<=122) || (c>=65 && c<=90); endfunction
    function bit digit(int unsigned c); return c >= 48 && c <= 57; endfunction

    function int solo_code(int unsigned c);
      case (c)
        123: return TK_LBRACE;   125: return TK_RBRACE;
        40:  return TK_LPAREN;   41:  return TK_RPAREN;
        91:  return TK_LBRACKET; 93:  return TK_RBRACKET;
        59:  return TK_SEMI;     58:  return TK_COLON;  44: return TK_COMMA;
        43:  return TK_PLUS;     45:  return TK_MINUS;  42: return TK_STAR;
        37:  return TK_PERCENT;
        default: return -1;
      endcase
    endfunction

    function logic [5:0] lone_op(logic [6:0] p);
      case (p)
        "/": return TK_SLASH; ">": return TK_GT; "<": return TK_LT;
        "=": return TK_ASSIGN; "!": return TK_NOT;
        default: return TK_UNKNOWN;
      endcase
    endfunction

    function void from_idle(int unsigned c);
      int s;
      s = solo_code(c);
      if (c == 32 || (c >= 9 && c <= 13)) return;
      if (letter(c) || c == "_") begin
        mode = SM_IDENT; kw_buf[0] = c[7:0]; id_len = 1; put(0, TK_IDENT, c);
      end else if (c == "\"") mode = SM_STR;
      else if (digit(c)) begin mode = SM_INT; put(0, TK_INT, c); end
      else if (c == ".") begin mode = SM_DOT; put(0, TK_FLOAT, c); end
      else if (s >= 0) put(1, 6'(s), 0);
      else if (c == "/" || c == "&" || c == "|" || c == ">" || c == "<" ||
               c == "=" || c == "!") begin
        op_char = c[6:0]; mode = SM_OP;
      end else put(1, TK_UNKNOWN, 0);
    endfunction

    function void close_again(logic [5:0] code, int unsigned c);
      put(1, code, 0); mode = SM_IDLE; from_idle(c);
    endfunction

    function void scan(int unsigned c);
      int h;
      logic [6:0] p;
      case (mode)
        SM_IDENT:
          if (letter(c) || digit(c) || c == "_") begin
            if (id_len < KwChars) kw_buf[id_len] = c[7:0];
            if (id_len <= KwChars) id_len++;
            put(0, TK_IDENT, c);
          end else close_again(word_code(), c);
        SM_INT:
          if (digit(c)) put(0, TK_INT, c);
          else if (c == ".") begin mode = SM_FRAC; put(0, TK_FLOAT, c); end
          else if (c == "e" || c == "E") begin mode = SM_EXP; put(0, TK_FLOAT, c); end
          else close_again(TK_INT, c);
        SM_DOT:
          if (digit(c)) begin mode = SM_FRAC; put(0, TK_FLOAT, c); end
          else close_again(TK_UNKNOWN, c);
        SM_FRAC:
          if (digit(c)) put(0, TK_FLOAT, c);
          else if (c == "e" || c == "E") begin mode = SM_EXP; put(0, TK_FLOAT, c); end
          else close_again(TK_FLOAT, c);
        SM_EXP:
          if (c == "+" || c == "-") begin mode = SM_EXPSIGN; put(0, TK_FLOAT, c); end
          else if (digit(c)) begin mode = SM_EXPDIG; put(0, TK_FLOAT, c); end
          else close_again(TK_UNKNOWN, c);
        SM_EXPSIGN:
          if (digit(c)) begin mode = SM_EXPDIG; put(0, TK_FLOAT, c); end
          else close_again(TK_UNKNOWN, c);
        SM_EXPDIG:
          if (digit(c)) put(0, TK_FLOAT, c);
          else close_again(TK_FLOAT, c);
        SM_STR:
          if (c == "\"") begin mode = SM_IDLE; put(1, TK_STRING, 0); end
          else if (c == "\\") mode = SM_ESC;
          else put(0, TK_STRING, c);
        SM_ESC: begin
          mode = SM_STR;
          case (c)
            "u": begin mode = SM_HEX; hex_acc = 0; hex_cnt = 0; end
            "b": put(0, TK_STRING, 8);
            "t": put(0, TK_STRING, 9);
            "n": put(0, TK_STRING, 10);
            "f": put(0, TK_STRING, 12);
            "r": put(0, TK_STRING, 13);
            "\"", "'", "\\": put(0, TK_STRING, c);
            default: close_again(TK_UNKNOWN, c);
          endcase
        end
        SM_HEX: begin
          if (digit(c)) h = c - 48;
          else if (c >= 65 && c <= 70) h = c - 55;
          else if (c >= 97 && c <= 102) h = c - 87;
          else h = -1;
          if (h < 0) close_again(TK_UNKNOWN, c);
          else begin
            hex_acc = ((hex_acc << 4) | h) & 16'hffff;
            hex_cnt++;
            if (hex_cnt >= 4) begin put(0, TK_STRING, hex_acc); hex_cnt = 0; mode = SM_STR; end
          end
        end
        SM_OP: begin
          p = op_char; op_char = '0; mode = SM_IDLE;
          if (p == "/" && c == "/") mode = SM_LINEC;
          else if (p == "/" && c == "*") mode = SM_BLOCK;
          else if (p == "&" && c == "&") put(1, TK_AND, 0);
          else if (p == "|" && c == "|") put(1, TK_OR, 0);
          else if (p == "=" && c == "=") put(1, TK_EQ, 0);
          else if (p == "!" && c == "=") put(1, TK_NE, 0);
          else if (p == ">" && c == "=") put(1, TK_GE, 0);
          else if (p == "<" && c == "=") put(1, TK_LE, 0);
          else close_again(lone_op(p), c);
        end
        SM_LINEC: if (c == 10 || c == 13) mode = SM_IDLE;
        SM_BLOCK: if (c == "*") mode = SM_BSTAR;
        SM_BSTAR:
          if (c == "/") mode = SM_IDLE;
          else if (c != "*") mode = SM_BLOCK;
        default: begin mode = SM_IDLE; from_idle(c); end
      endcase
    endfunction

    // Notes one accepted input item and queues the results it causes.
    function void note_input(in_item_t it);
      int unsigned b, c;
      out_item_t r;
      step_res.delete();
      b = it.data_byte;
      if (it.end_mark) begin
        if (col_no < PosMax) col_no++;
        case (mode)
          SM_IDENT: put(1, word_code(), 0);
          SM_INT: put(1, TK_INT, 0);
          SM_FRAC, SM_EXPDIG: put(1, TK_FLOAT, 0);
          SM_DOT, SM_EXP, SM_EXPSIGN, SM_STR, SM_ESC, SM_HEX: put(1, TK_UNKNOWN, 0);
          SM_OP: put(1, lone_op(op_char), 0);
          default: ;
        endcase
        put(1, TK_EOF, 0);
        mode = SM_IDLE; op_char = '0; u8_acc = 0; u8_left = 0; hex_cnt = 0; hex_acc = 0;
      end else begin
        if (u8_left > 0) begin
          u8_acc = ((u8_acc << 6) | (b & 6'h3f)) & 21'h1fffff; u8_left--;
        end else if (b < 8'h80) u8_acc = b;
        else if (b >= 8'hf0) begin u8_acc = b & 7; u8_left = 3; end
        else if (b >= 8'he0) begin u8_acc = b & 15; u8_left = 2; end
        else begin u8_acc = b & 31; u8_left = 1; end
        if (u8_left == 0) begin
          c = u8_acc; u8_acc = 0;
          if (col_no < PosMax) col_no++;
          if (c == 10 || c == 13) begin
            if (line_no < PosMax) line_no++;
            col_no = 0;
          end
          scan(c);
        end
      end
      foreach (step_res[i]) begin
        r = step_res[i];
        r.last = (i == step_res.size() - 1);
        pending = {pending, r};
      end
    endfunction

    // Checks one accepted result against the oldest prediction.
    task check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result %p", got));
        return;
      end
      want = pending.pop_front();
      if (got.out_kind != want.out_kind)
        report($sformatf("out_kind %0d want %0d", got.out_kind, want.out_kind));
      if (got.token_code != want.token_code)
        report($sformatf("token_code %0d want %0d", got.token_code, want.token_code));
      if (got.code_point != want.code_point)
        report($sformatf("code_point %0h want %0h", got.code_point, want.code_point));
      if (got.line != want.line)
        report($sformatf("line %0d want %0d", got.line, want.line));
      if (got.column != want.column)
        report($sformatf("column %0d want %0d", got.column, want.column));
      if (got.last != want.last)
        report($sformatf("last %0d want %0d", got.last, want.last));
    endtask
  endclass

  token_scoreboard tokens;

  script_source_tokenizer u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_item_i(in_item),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_item_o(out_item)
  );

  initial clk = 0;
  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // Monitor: record accepted items on the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) tokens.note_input(in_item);
      if (out_valid && !out_stall) tokens.check_result(out_item);
    end
  end

  // Cycle counter with a timeout.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleCap) begin
      $display("timeout");
      $display("[script_source_tokenizer] ERROR");
      $finish;
    end
  end

  // Receiver stalls: random bursts, one long hold-off, none in the quiet tail.
  initial begin
    int n;
    out_stall = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_stall <= 1;
        repeat (60) @(negedge clk);
        long_hold = 0;
        out_stall <= 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 14);
        out_stall <= 1;
        repeat (n) @(negedge clk);
        out_stall <= 0;
      end
    end
  end

  // Offers one item and holds it until accepted, with random gaps before it.
  task automatic send(input logic [7:0] b, input bit fin);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_item.data_byte <= b;
    in_item.end_mark  <= fin;
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send(s[i], 0);
  endtask

  task automatic send_end();
    send(8'($urandom_range(0, 255)), 1);
  endtask

  // Waits, input idle, until every predicted result has been checked.
  task automatic drain();
    in_valid <= 0;
    while (tokens.pending.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Random fragment of well-formed source text.
  function automatic string fragment();
    string words [14] = '{"else", "false", "for", "function", "if", "null", "return",
                          "true", "var", "while", "functions", "_x9", "abcdefghij", "Zq"};
    string ops [20] = '{"==", "!=", ">=", "<=", "&&", "||", "=", "!", "<", ">", "/",
                        "{", "}", "(", ")", "[", "]", ";", ":", ","};
    string s;
    case ($urandom_range(0, 9))
      0, 1: s = words[$urandom_range(0, 13)];
      2: s = $sformatf("%0d", $urandom);
      3: s = $sformatf("%0d.%0de%s%0d", $urandom_range(0, 99), $urandom_range(0, 999),
                       $urandom_range(0, 1) ? "-" : "+", $urandom_range(0, 40));
      4: s = {"\"a\\n\\t\\u", $sformatf("%04x", $urandom_range(0, 65535)), "\\\"q\""};
      5: s = "/* c * */";
      6: s = "// note\n";
      7: s = "+-*%";
      default: s = ops[$urandom_range(0, 19)];
    endcase
    return {s, ($urandom_range(0, 3) == 0) ? "\n" : " "};
  endfunction

  // Main stimulus.
  initial begin
    string s;
    tokens = new();
    tokens.clear();
    mismatches = 0; cycles = 0; long_hold = 0; quiet = 0;
    in_valid = 0; in_item = '0; rst_n = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed: keywords, numbers, strings with escapes, operators, comments, UTF-8.
    send_text("while x1 3.5e-2 .7 \"\\u00e9\\b\\f\\r\\'\\z\"");
    send_text("<= & | a//c\n/**/ 1e 2.e+ #");
    send(8'hf4, 0); send(8'h8f, 0); send(8'hbf, 0); send(8'hbf, 0);
    send(8'he2, 0); send(8'h82, 0); send(8'hac, 0); send(8'hc3, 0); send(8'ha9, 0);
    send_text("\"\\uzz 9e"); send_end();
    send_text("\"ab"); send_end();
    send_text("/* open"); send_end();
    send_text("="); send(8'hff, 0); send_end();
    drain();

    // Random part: mostly well-formed text, some raw byte noise.
    for (int n = 0; n < 320; ) begin
      if ($urandom_range(0, 9) == 0) begin
        send($urandom_range(0, 255), 0); n++;
      end else begin
        s = fragment();
        send_text(s); n += s.len();
      end
      if ($urandom_range(0, 30) == 0) begin send_end(); n++; end
      if (n > 120 && n < 140) long_hold = 1;
      if (n > 200 && n < 215) drain();
      if (n > 270) quiet = 1;
    end
    send_end();
    drain();
    repeat (20) @(negedge clk);
    if (tokens.pending.size() != 0) report("results still expected at end");
    if (mismatches == 0) $display("[script_source_tokenizer] OK");
    else $display("[script_source_tokenizer] ERROR");
    $finish;
  end
endmodule
